>>> rtl/core/tadh_pkg.sv
package tadh_pkg;

  localparam int NBIN_DEFAULT       = 32;
  localparam int COUNT_BITS_DEFAULT = 24;

  // Cell addresses travel at the width of the largest supported store.
  localparam int ADDR_MAX_BITS = 16;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [31:0] INV_BIN_WIDTH_RESET = 32'd65536;
  localparam logic [15:0] START_FRAME_RESET   = 16'd150;
  localparam logic [31:0] DENSITY_SCALE_RESET = 32'd65536;

  localparam logic [1:0] CFG_INV_BIN_WIDTH = 2'd0;
  localparam logic [1:0] CFG_START_FRAME   = 2'd1;
  localparam logic [1:0] CFG_DENSITY_SCALE = 2'd2;

  typedef enum logic [1:0] {
    OP_PARTICLE  = 2'd0,
    OP_FRAME_END = 2'd1,
    OP_READ      = 2'd2,
    OP_CLEAR     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EARLY = 2'd2
  } status_e;

  // What the back end does with a queued entry.
  typedef enum logic [1:0] {
    K_REPLY = 2'd0,
    K_INC   = 2'd1,
    K_READ  = 2'd2,
    K_CLEAR = 2'd3
  } kind_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [4:0]  cell_x;
    logic [4:0]  cell_y;
  } cmd_t;

  typedef struct packed {
    logic [23:0] cell_count;
    logic [55:0] density;
    logic [31:0] total_count;
    logic [15:0] frame_number;
    status_e     status;
  } res_t;

  typedef struct packed {
    kind_e                    kind;
    status_e                  status;
    logic [ADDR_MAX_BITS-1:0] addr;
    logic [31:0]              total;
    logic [15:0]              frame;
  } entry_t;

endpackage

>>> rtl/core/time_averaged_density_histogram_unit.sv
// Two-dimensional particle histogram with a command front end and a store back end.
// A command is taken when start_i is high and busy_o is low. On a particle beat the
// front end holds busy_o through two passes through its one 32x32 multiplier to
// scale x and y, then a hand-off; on the other commands only through the hand-off.
// The hand-off waits, and busy_o stays high, while the two-entry queue to the back
// end is full. The back end reads the addressed counter, increments it on a
// particle and scales it, and sends end-of-frame and out-of-range replies without
// a lookup; it finishes each entry before it takes the next. Each
// command yields exactly one result beat: done_o is high for one cycle with the
// beat on res_o, and it cannot be held off. After reset and after every clear
// command the back end zeroes the count store, one cell per cycle, all NBIN*NBIN
// cells (1024 by default); commands queue meanwhile and busy_o stays high once
// the queue fills. Configuration writes take effect at once and belong to idle
// periods only.
module time_averaged_density_histogram_unit import tadh_pkg::*; #(
  parameter int NBIN       = NBIN_DEFAULT,
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  cmd_t        cmd_i,
  output logic        done_o,
  output res_t        res_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] inv_bin_width_q;
  logic [15:0] start_frame_q;
  logic [31:0] density_scale_q;

  logic   push;
  logic   pop;
  logic   full;
  logic   empty;
  entry_t push_entry;
  entry_t head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_bin_width_q <= INV_BIN_WIDTH_RESET;
      start_frame_q   <= START_FRAME_RESET;
      density_scale_q <= DENSITY_SCALE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_INV_BIN_WIDTH: inv_bin_width_q <= cfg_data_i;
        CFG_START_FRAME:   start_frame_q   <= cfg_data_i[15:0];
        CFG_DENSITY_SCALE: density_scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tadh_front #(
    .NBIN (NBIN)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .cmd_i           (cmd_i),
    .inv_bin_width_i (inv_bin_width_q),
    .start_frame_i   (start_frame_q),
    .push_o          (push),
    .entry_o         (push_entry),
    .full_i          (full)
  );

  tadh_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty)
  );

  tadh_back #(
    .NBIN       (NBIN),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .empty_i         (empty),
    .pop_o           (pop),
    .density_scale_i (density_scale_q),
    .done_o          (done_o),
    .res_o           (res_o)
  );

endmodule

>>> rtl/core/tadh_front.sv
module tadh_front import tadh_pkg::*; #(
  parameter int NBIN = NBIN_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  cmd_t        cmd_i,
  input  logic [31:0] inv_bin_width_i,
  input  logic [15:0] start_frame_i,
  output logic        push_o,
  output entry_t      entry_o,
  input  logic        full_i
);

  localparam int CW = (NBIN > 1) ? $clog2(NBIN) : 1;
  localparam int AW = $clog2(NBIN * NBIN);

  typedef enum logic [1:0] {
    F_IDLE,
    F_MULX,
    F_MULY,
    F_PUSH
  } fstate_e;

  fstate_e     state_q;
  logic [15:0] frame_q;
  logic [31:0] total_q;

  cmd_t          cmd_q;
  logic [63:0]   prod_q;
  logic          x_ok_q;
  logic [CW-1:0] ix_q;

  logic          y_ok;
  logic [CW-1:0] iy;
  logic          rd_ok;
  logic [AW-1:0] hit_addr;
  logic [AW-1:0] rd_addr;
  entry_t        entry;

  assign y_ok  = prod_q[63:32] < 32'(NBIN);
  assign iy    = prod_q[32 +: CW];
  assign rd_ok = (32'(cmd_q.cell_x) < 32'(NBIN)) && (32'(cmd_q.cell_y) < 32'(NBIN));
  assign hit_addr = AW'(ix_q) * AW'(NBIN) + AW'(iy);
  assign rd_addr  = AW'(CW'(cmd_q.cell_x)) * AW'(NBIN) + AW'(CW'(cmd_q.cell_y));

  always_comb begin
    entry        = '0;
    entry.kind   = K_REPLY;
    entry.status = ST_OK;
    entry.total  = total_q;
    entry.frame  = frame_q;
    unique case (cmd_q.op)
      OP_PARTICLE: begin
        if (frame_q < start_frame_i) begin
          entry.status = ST_EARLY;
        end else if (!(x_ok_q && y_ok)) begin
          entry.status = ST_RANGE;
        end else begin
          entry.kind  = K_INC;
          entry.addr  = ADDR_MAX_BITS'(hit_addr);
          entry.total = (&total_q) ? total_q : total_q + 32'd1;
        end
      end
      OP_FRAME_END: begin
        entry.frame = (&frame_q) ? frame_q : frame_q + 16'd1;
      end
      OP_READ: begin
        if (rd_ok) begin
          entry.kind = K_READ;
          entry.addr = ADDR_MAX_BITS'(rd_addr);
        end else begin
          entry.status = ST_RANGE;
        end
      end
      OP_CLEAR: begin
        entry.kind  = K_CLEAR;
        entry.total = '0;
        entry.frame = '0;
      end
      default: ;
    endcase
  end

  assign push_o  = (state_q == F_PUSH) && !full_i;
  assign entry_o = entry;
  assign busy_o  = state_q != F_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      frame_q <= '0;
      total_q <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (start_i) begin
            state_q <= (cmd_i.op == OP_PARTICLE) ? F_MULX : F_PUSH;
          end
        end
        F_MULX: state_q <= F_MULY;
        F_MULY: state_q <= F_PUSH;
        F_PUSH: begin
          if (!full_i) begin
            frame_q <= entry.frame;
            total_q <= entry.total;
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  // One shared multiplier scales x, then y, to the cell grid.
  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && start_i) begin
      cmd_q <= cmd_i;
    end
    if (state_q == F_MULX) begin
      prod_q <= 64'(cmd_q.pos_x) * 64'(inv_bin_width_i);
    end
    if (state_q == F_MULY) begin
      x_ok_q <= prod_q[63:32] < 32'(NBIN);
      ix_q   <= prod_q[32 +: CW];
      prod_q <= 64'(cmd_q.pos_y) * 64'(inv_bin_width_i);
    end
  end

endmodule

>>> rtl/core/tadh_queue.sv
module tadh_queue import tadh_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output entry_t head_o,
  output logic   empty_o
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  entry_t        slot_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q;
  logic [PW-1:0] rd_q;
  logic [PW:0]   cnt_q;

  assign full_o  = cnt_q == (PW+1)'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (PW+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= entry_i;
    end
  end

endmodule

>>> rtl/core/tadh_back.sv
module tadh_back import tadh_pkg::*; #(
  parameter int NBIN       = NBIN_DEFAULT,
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  entry_t      head_i,
  input  logic        empty_i,
  output logic        pop_o,
  input  logic [31:0] density_scale_i,
  output logic        done_o,
  output res_t        res_o
);

  localparam int AW    = $clog2(NBIN * NBIN);
  localparam int CELLS = NBIN * NBIN;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_RD,
    B_MUL,
    B_OUT
  } bstate_e;

  bstate_e state_q;
  logic [AW-1:0] clr_q;
  logic          done_q;
  res_t          res_q;

  entry_t                ent_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic [63:0]           prod_q;

  logic [COUNT_BITS-1:0] mem [CELLS];
  logic [COUNT_BITS-1:0] rdata_q;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [COUNT_BITS-1:0] cnt_d;
  logic [31:0]           cnt32;
  logic                  reply_now;

  assign pop_o = (state_q == B_IDLE) && !empty_i;
  assign cnt_d = (ent_q.kind == K_INC && !(&rdata_q)) ? rdata_q + COUNT_BITS'(1) : rdata_q;
  assign cnt32 = 32'(cnt_q);
  assign reply_now = pop_o && (head_i.kind == K_REPLY || head_i.kind == K_CLEAR);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ent_q.addr[AW-1:0];
    mem_wdata = cnt_d;
    if (state_q == B_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (state_q == B_RD && ent_q.kind == K_INC) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[head_i.addr[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      done_q <= reply_now || (state_q == B_OUT);
      unique case (state_q)
        B_CLEAR: begin
          if (clr_q == AW'(CELLS - 1)) begin
            clr_q   <= '0;
            state_q <= B_IDLE;
          end else begin
            clr_q <= clr_q + AW'(1);
          end
        end
        B_IDLE: begin
          if (reply_now) begin
            // Nothing to look up: the beat goes out right away.
            res_q <= '{cell_count: '0, density: '0, total_count: head_i.total,
                       frame_number: head_i.frame, status: head_i.status};
            state_q <= (head_i.kind == K_CLEAR) ? B_CLEAR : B_IDLE;
          end else if (!empty_i) begin
            state_q <= B_RD;
          end
        end
        B_RD:  state_q <= B_MUL;
        B_MUL: state_q <= B_OUT;
        B_OUT: begin
          res_q.cell_count   <= cnt32[23:0];
          res_q.density      <= (|prod_q[63:56]) ? {56{1'b1}} : prod_q[55:0];
          res_q.total_count  <= ent_q.total;
          res_q.frame_number <= ent_q.frame;
          res_q.status       <= ent_q.status;
          state_q            <= B_IDLE;
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ent_q <= head_i;
    end
    if (state_q == B_RD) begin
      cnt_q <= cnt_d;
    end
    if (state_q == B_MUL) begin
      prod_q <= 64'(cnt32) * 64'(density_scale_i);
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
